// File: rtl/core/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
`default_nettype none
package pfa_pkg;
	localparam int unsigned FRAME_SHIFT = 12;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned FN_W = 20;

	typedef enum logic [1:0] {
		FN_ADD     = 2'd0,
		FN_REQUEST = 2'd1,
		FN_RESERVE = 2'd2,
		FN_FREE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID      = 3'd1,
		ST_NONE_FREE    = 3'd2,
		ST_UNALIGNED    = 3'd3,
		ST_ALREADY_FREE = 3'd4,
		ST_ALREADY_USED = 3'd5,
		ST_ORDER        = 3'd6,
		ST_FULL         = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic [31:0] length;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      grant_addr;
		logic [CNT_W-1:0] frame_count;
		logic [CNT_W-1:0] used_count;
		logic [CNT_W-1:0] next_index;
	} rsp_t;

	// One memory access issued by the sequencer.
	typedef struct packed {
		logic          rd;
		logic          wr;
		logic          wr_fn;
		logic [FN_W-1:0] fn;
		logic          used;
	} mem_op_t;
endpackage
`default_nettype wire

// File: rtl/core/pfa_table.sv
// Frame table memory: frame number and in-use flag per entry, registered read.
`default_nettype none
module pfa_table #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  wire logic               clk,
	input  wire pfa_pkg::mem_op_t   op,
	input  wire logic [AW-1:0]      addr,
	output logic [pfa_pkg::FN_W-1:0] rd_fn,
	output logic                    rd_used
);
	import pfa_pkg::*;

	logic [FN_W-1:0] fn_mem [DEPTH];
	logic            used_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (op.wr) begin
			if (op.wr_fn) fn_mem[addr] <= op.fn;
			used_mem[addr] <= op.used;
		end
		if (op.rd) begin
			rd_fn <= fn_mem[addr];
			rd_used <= used_mem[addr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/page_frame_allocator.sv
// Top level: next-fit page frame allocator sequencing over the frame table.
//
//  channel   signals                 direction  beat taken when
//  command   start, busy, cmd        in         start && !busy
//  result    done, rsp               out        done (one cycle)
//
// Add region writes one entry per cycle.
// Request, reserve and free read one entry at a time through the registered
// table port: each entry is read in S_RD and tested in S_TEST before the next.
// Reset clears state, counters and last region end, not the table; table entries are read only below table_count.
// The receiver cannot stall; the result shows for one cycle with done.
`default_nettype none
module page_frame_allocator #(
	parameter int unsigned MAX_FRAMES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pfa_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output pfa_pkg::rsp_t      rsp
);
	import pfa_pkg::*;

	localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CW = $clog2(MAX_FRAMES + 1) + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADD  = 5'b00010,
		S_RD   = 5'b00100,
		S_TEST = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic [CW-1:0] count_q, start_q, used_q, idx_q, checked_q, n_q;
	logic [31:0]   prev_end_q, next_addr_q, grant_q;
	logic [2:0]    status_q;
	logic          full_q;

	mem_op_t op;
	logic [AW-1:0] maddr;
	logic [FN_W-1:0] rd_fn;
	logic rd_used;

	pfa_table #(.DEPTH(MAX_FRAMES), .AW(AW)) u_table (
		.clk(clk), .op(op), .addr(maddr), .rd_fn(rd_fn), .rd_used(rd_used)
	);

	// add region decode
	logic [31:0] a_end, a_gap, a_size, a_aligned;
	logic [19:0] a_frames;
	logic [CW-1:0] a_room, a_n;
	always_comb begin
		a_end = cmd.address + cmd.length;
		a_gap = 32'd4096 - {20'd0, cmd.address[11:0]};
		if (cmd.address[11:0] == 12'd0) begin
			a_aligned = cmd.address;
			a_size = cmd.length;
		end else begin
			a_aligned = cmd.address + a_gap;
			a_size = (a_gap > cmd.length) ? 32'd0 : cmd.length - a_gap;
		end
		a_frames = a_size[31:12];
		a_room = CW'(MAX_FRAMES) - count_q;
		a_n = ({12'd0, a_frames} < 32'(a_room)) ? CW'(a_frames) : a_room;
	end

	logic hit;
	assign hit = ({rd_fn, 12'd0} == cmd_q.address);

	always_comb begin
		op = '0;
		maddr = idx_q[AW-1:0];
		case (state_q)
			S_ADD: begin
				// hold the table once the last frame is in
				if (n_q != '0) begin
					op.wr = 1'b1;
					op.wr_fn = 1'b1;
					op.fn = next_addr_q[31:12];
					op.used = 1'b0;
				end
				maddr = count_q[AW-1:0];
			end
			S_RD: op.rd = 1'b1;
			S_TEST: begin
				if (cmd_q.func == FN_REQUEST && !rd_used) begin
					op.wr = 1'b1;
					op.used = 1'b1;
				end else if (cmd_q.func != FN_REQUEST && hit) begin
					op.wr = (cmd_q.func == FN_RESERVE) ? !rd_used : rd_used;
					op.used = (cmd_q.func == FN_RESERVE);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			start_q <= '0;
			used_q <= '0;
			prev_end_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					grant_q <= '0;
					status_q <= ST_OK;
					checked_q <= '0;
					idx_q <= '0;
					state_q <= S_DONE;
					unique case (func_t'(cmd.func))
						FN_ADD: begin
							if (a_end <= prev_end_q) status_q <= ST_ORDER;
							else begin
								prev_end_q <= a_end;
								full_q <= (32'(a_n) < {12'd0, a_frames});
								n_q <= a_n;
								next_addr_q <= a_aligned;
								state_q <= S_ADD;
							end
						end
						FN_REQUEST: begin
							if (count_q == '0) status_q <= ST_NONE_FREE;
							else begin
								idx_q <= (start_q >= count_q) ? '0 : start_q;
								state_q <= S_RD;
							end
						end
						default: begin
							if (cmd.address[11:0] != 12'd0) status_q <= ST_UNALIGNED;
							else if (count_q == '0) status_q <= ST_INVALID;
							else state_q <= S_RD;
						end
					endcase
				end
				S_ADD: begin
					if (n_q == '0) begin
						if (full_q) status_q <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						count_q <= count_q + 1'b1;
						n_q <= n_q - 1'b1;
						next_addr_q <= next_addr_q + 32'd4096;
					end
				end
				S_RD: state_q <= S_TEST;
				S_TEST: begin
					state_q <= S_RD;
					if (cmd_q.func == FN_REQUEST) begin
						if (!rd_used) begin
							grant_q <= {rd_fn, 12'd0};
							used_q <= used_q + 1'b1;
							start_q <= idx_q + 1'b1;
							state_q <= S_DONE;
						end else begin
							start_q <= idx_q + 1'b1;
							checked_q <= checked_q + 1'b1;
							idx_q <= (idx_q + 1'b1 >= count_q) ? '0 : idx_q + 1'b1;
							if (checked_q + 1'b1 >= count_q) begin
								status_q <= ST_NONE_FREE;
								state_q <= S_DONE;
							end
						end
					end else if (hit) begin
						state_q <= S_DONE;
						if (cmd_q.func == FN_RESERVE) begin
							if (rd_used) status_q <= ST_ALREADY_USED;
							else used_q <= used_q + 1'b1;
						end else begin
							if (!rd_used) status_q <= ST_ALREADY_FREE;
							else used_q <= used_q - 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						if (idx_q + 1'b1 >= count_q) begin
							status_q <= ST_INVALID;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp.status = status_q;
		rsp.grant_addr = grant_q;
		rsp.frame_count = count_q[CNT_W-1:0];
		rsp.used_count = used_q[CNT_W-1:0];
		rsp.next_index = start_q[CNT_W-1:0];
	end

	a_used_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= count_q) else $error("used count exceeds table count");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAMES)) else $error("table count overflow");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held more than one cycle");
endmodule
`default_nettype wire
